// ----- design/hss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hss_pkg: shared types and constants of the humidity sensor sequencer
// Sequence state codes, command words, configuration indexes and the structs
// passed between the configuration, step and top-level modules.
// ----------------------------------------------------------------------------
package hss_pkg;

	// sequence state codes
	localparam logic [2:0] ST_BOOT     = 3'd0;
	localparam logic [2:0] ST_STATUS   = 3'd1;
	localparam logic [2:0] ST_EVAL     = 3'd2;
	localparam logic [2:0] ST_SEND_CAL = 3'd3;
	localparam logic [2:0] ST_IDLE     = 3'd4;
	localparam logic [2:0] ST_TRIGGER  = 3'd5;
	localparam logic [2:0] ST_WAIT     = 3'd6;
	localparam logic [2:0] ST_FETCH    = 3'd7;

	// item operation codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_TRIGGER = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_POWER_ON_DELAY = 2'd1;
	localparam logic [1:0] CFG_MEASURE_WAIT   = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;

	// command words and status bits
	localparam logic [23:0] CMD_CALIBRATE = 24'hBE0800;
	localparam logic [23:0] CMD_MEASURE   = 24'hAC3300;
	localparam int unsigned STATUS_CAL_BIT  = 3;
	localparam int unsigned STATUS_BUSY_BIT = 7;

	localparam logic [2:0] LEN_STATUS  = 3'd1;
	localparam logic [2:0] LEN_MEASURE = 3'd6;

	// conversion scale factors and temperature offset
	localparam logic [9:0]  HUM_SCALE   = 10'd1000;
	localparam logic [10:0] TEMP_SCALE  = 11'd2000;
	localparam logic [11:0] TEMP_OFFSET = 12'd500;

	// register reset values
	localparam logic [15:0] POWER_ON_DELAY_RST = 16'd40;
	localparam logic [15:0] MEASURE_WAIT_RST   = 16'd80;
	localparam logic signed [11:0] TEMP_RST    = -12'sd500;

	typedef struct packed {
		logic [15:0] power_on_delay_ms;
		logic [15:0] measure_wait_ms;
	} cfg_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] now_ms;
		logic        bus_busy;
		logic        rx_ready;
		logic [47:0] rx_bytes;
	} item_t;

	typedef struct packed {
		logic [2:0]          seq_state;
		logic [31:0]         start_time;
		logic [9:0]          humidity;
		logic signed [11:0]  temperature;
		logic                value_valid;
	} seq_t;

	typedef struct packed {
		logic               trigger_accepted;
		logic               issue_write;
		logic [23:0]        command_bytes;
		logic               issue_read;
		logic [2:0]         read_length;
		logic               rx_taken;
		logic [9:0]         humidity_tenths;
		logic signed [11:0] temperature_tenths;
		logic               reading_valid;
	} result_t;

endpackage
`default_nettype wire

// ----- design/humidity_sensor_sequencer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_sensor_sequencer_unit: I2C humidity/temperature sensor sequencer
// Steps the power-on, status, calibrate and measure sequence once per word
// and reports bus requests and the last converted reading.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall is low and returns one result word
// per input word. An accepted word sits in the input register; the step logic
// (state update and the two 20-bit by constant conversion multipliers) loads
// its result into the result register once that register can advance, and the
// result is offered from there. A result waiting under
// out_stall holds the result register; the input register still takes one
// more word, and in_stall rises only once both are full. Configuration writes
// are taken at any time and should be made only while no word is in flight.
// ----------------------------------------------------------------------------
module humidity_sensor_sequencer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_write,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           operation,
	input  wire logic [31:0]                    now_ms,
	input  wire logic                           bus_busy,
	input  wire logic                           rx_ready,
	input  wire logic [47:0]                    rx_bytes,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                trigger_accepted,
	output logic                                issue_write,
	output logic [23:0]                         command_bytes,
	output logic                                issue_read,
	output logic [2:0]                          read_length,
	output logic                                rx_taken,
	output logic [9:0]                          humidity_tenths,
	output logic signed [11:0]                  temperature_tenths,
	output logic                                reading_valid
);

	hss_pkg::cfg_t    cfg;
	hss_pkg::item_t   item_s1;
	logic             valid_s1;
	hss_pkg::result_t res_s2;
	logic             valid_s2;
	hss_pkg::seq_t    seq_q;
	hss_pkg::seq_t    seq_nxt;
	hss_pkg::result_t res_nxt;
	logic             advance;
	logic             load_s1;

	hss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hss_step u_step (
		.item (item_s1),
		.cur  (seq_q),
		.cfg  (cfg),
		.nxt  (seq_nxt),
		.res  (res_nxt)
	);

	// pipeline flow control; the input register fills while the result waits
	assign advance  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = valid_s1 && !advance;

	// valid bits and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			valid_s2          <= 1'b0;
			seq_q.seq_state   <= hss_pkg::ST_BOOT;
			seq_q.start_time  <= '0;
			seq_q.humidity    <= '0;
			seq_q.temperature <= hss_pkg::TEMP_RST;
			seq_q.value_valid <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= in_valid;
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1)
					seq_q <= seq_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.operation <= operation;
			item_s1.now_ms    <= now_ms;
			item_s1.bus_busy  <= bus_busy;
			item_s1.rx_ready  <= rx_ready;
			item_s1.rx_bytes  <= rx_bytes;
		end
		if (advance)
			res_s2 <= res_nxt;
	end

	// result word
	assign out_valid          = valid_s2;
	assign trigger_accepted   = res_s2.trigger_accepted;
	assign issue_write        = res_s2.issue_write;
	assign command_bytes      = res_s2.command_bytes;
	assign issue_read         = res_s2.issue_read;
	assign read_length        = res_s2.read_length;
	assign rx_taken           = res_s2.rx_taken;
	assign humidity_tenths    = res_s2.humidity_tenths;
	assign temperature_tenths = res_s2.temperature_tenths;
	assign reading_valid      = res_s2.reading_valid;

	// checks
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");

	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(seq_q.value_valid) |-> seq_q.value_valid)
		else $error("stored reading lost its valid flag");

	a_write_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && issue_write |->
			command_bytes == hss_pkg::CMD_CALIBRATE ||
			command_bytes == hss_pkg::CMD_MEASURE)
		else $error("unknown command word");

	a_read_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> issue_read == (read_length != 3'd0))
		else $error("read length does not match read request");

	a_trigger_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_accepted |-> !issue_write && !issue_read && !rx_taken)
		else $error("trigger word issued a bus request");

endmodule
`default_nettype wire

// ----- design/hss_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hss_cfg_regs: configuration registers
// Plain write port. A write to the bus address index is taken and dropped
// here; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module hss_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [hss_pkg::CFG_DATA_W-1:0]    cfg_data,
	output hss_pkg::cfg_t                          cfg
);

	hss_pkg::cfg_t cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_on_delay_ms <= hss_pkg::POWER_ON_DELAY_RST;
			cfg_q.measure_wait_ms   <= hss_pkg::MEASURE_WAIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				hss_pkg::CFG_DEVICE_ADDRESS: begin
					cfg_q <= cfg_q;
				end
				hss_pkg::CFG_POWER_ON_DELAY: begin
					cfg_q.power_on_delay_ms <= cfg_data[15:0];
				end
				hss_pkg::CFG_MEASURE_WAIT: begin
					cfg_q.measure_wait_ms <= cfg_data[15:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- design/hss_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hss_step: one step of the sequencer
// Combinational next state and result word for the item held in the input
// register, including the raw-to-tenths conversion of a measurement.
// ----------------------------------------------------------------------------
module hss_step (
	input  wire hss_pkg::item_t item,
	input  wire hss_pkg::seq_t  cur,
	input  wire hss_pkg::cfg_t  cfg,
	output hss_pkg::seq_t       nxt,
	output hss_pkg::result_t    res
);

	logic [7:0]  status_byte;
	logic [19:0] raw_h;
	logic [19:0] raw_t;
	logic [29:0] hum_prod;
	logic [30:0] temp_prod;
	logic [9:0]  hum_conv;
	logic [10:0] temp_conv;
	logic [31:0] elapsed;

	// unpack and scale the measurement bytes
	assign status_byte = item.rx_bytes[47:40];
	assign raw_h       = item.rx_bytes[39:20];
	assign raw_t       = item.rx_bytes[19:0];
	assign hum_prod    = raw_h * hss_pkg::HUM_SCALE;
	assign temp_prod   = raw_t * hss_pkg::TEMP_SCALE;
	assign hum_conv    = hum_prod[29:20];
	assign temp_conv   = temp_prod[30:20];

	// wrapping time since the last command
	assign elapsed = item.now_ms - cur.start_time;

	// sequence step
	always_comb begin
		nxt = cur;
		res = '0;
		if (item.operation == hss_pkg::OP_TRIGGER) begin
			if (cur.seq_state == hss_pkg::ST_IDLE) begin
				nxt.seq_state        = hss_pkg::ST_TRIGGER;
				res.trigger_accepted = 1'b1;
			end
		end else begin
			case (cur.seq_state)
				hss_pkg::ST_BOOT: begin
					if (item.now_ms > {16'd0, cfg.power_on_delay_ms})
						nxt.seq_state = hss_pkg::ST_STATUS;
				end
				hss_pkg::ST_STATUS: begin
					if (!item.bus_busy) begin
						res.issue_read  = 1'b1;
						res.read_length = hss_pkg::LEN_STATUS;
						nxt.seq_state   = hss_pkg::ST_EVAL;
					end
				end
				hss_pkg::ST_EVAL: begin
					if (item.rx_ready) begin
						res.rx_taken  = 1'b1;
						nxt.seq_state = status_byte[hss_pkg::STATUS_CAL_BIT] ?
							hss_pkg::ST_IDLE : hss_pkg::ST_SEND_CAL;
					end
				end
				hss_pkg::ST_SEND_CAL, hss_pkg::ST_TRIGGER: begin
					if (!item.bus_busy) begin
						res.issue_write   = 1'b1;
						res.command_bytes = (cur.seq_state == hss_pkg::ST_SEND_CAL) ?
							hss_pkg::CMD_CALIBRATE : hss_pkg::CMD_MEASURE;
						nxt.start_time    = item.now_ms;
						nxt.seq_state     = hss_pkg::ST_WAIT;
					end
				end
				hss_pkg::ST_IDLE: begin
					nxt.seq_state = hss_pkg::ST_IDLE;
				end
				hss_pkg::ST_WAIT: begin
					if (elapsed >= {16'd0, cfg.measure_wait_ms}) begin
						res.issue_read  = 1'b1;
						res.read_length = hss_pkg::LEN_MEASURE;
						nxt.seq_state   = hss_pkg::ST_FETCH;
					end
				end
				default: begin
					// fetch: take the six bytes, keep old values if sensor busy
					if (item.rx_ready) begin
						res.rx_taken = 1'b1;
						if (!status_byte[hss_pkg::STATUS_BUSY_BIT]) begin
							nxt.humidity    = hum_conv;
							nxt.temperature = $signed({1'b0, temp_conv}
								- hss_pkg::TEMP_OFFSET);
							nxt.value_valid = 1'b1;
						end
						nxt.seq_state = hss_pkg::ST_IDLE;
					end
				end
			endcase
		end
		// stored values as they stand after this step
		res.humidity_tenths    = nxt.humidity;
		res.temperature_tenths = nxt.temperature;
		res.reading_valid      = nxt.value_valid;
	end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for humidity_sensor_sequencer_unit
// Steps the sequencer through power-on, status read, calibration and
// measurement cycles. A scoreboard predicts one result word per accepted
// input word and checks the results in order. Both channels idle and stall
// at random, and the timing registers are rewritten between phases.
// ----------------------------------------------------------------------------

import hss_pkg::*;

// Predicts the sequencer and checks its result words in order
class reading_scoreboard;
	logic [2:0]  seq_state;
	logic [31:0] start_ms;
	logic [9:0]  hum_tenths;
	logic [10:0] temp_scaled;
	logic        have_reading;
	logic [6:0]  dev_addr;
	logic [15:0] boot_delay;
	logic [15:0] wait_ms;
	result_t     pending_results[$];
	int          fails;
	int          checked;
	int          readings_stored;

	function new();
		seq_state       = ST_BOOT;
		start_ms        = '0;
		hum_tenths      = '0;
		temp_scaled     = '0;
		have_reading    = 1'b0;
		dev_addr        = 7'h38;
		boot_delay      = POWER_ON_DELAY_RST;
		wait_ms         = MEASURE_WAIT_RST;
		fails           = 0;
		checked         = 0;
		readings_stored = 0;
	endfunction

	// register write; the unused index is dropped
	function void write_reg(logic [1:0] idx, logic [15:0] data);
		case (idx)
			CFG_DEVICE_ADDRESS: dev_addr   = data[6:0];
			CFG_POWER_ON_DELAY: boot_delay = data;
			CFG_MEASURE_WAIT:   wait_ms    = data;
			default: ;
		endcase
	endfunction

	// one accepted input word: advance the sequence and queue its result
	function void note_word(item_t w);
		result_t     r;
		logic [31:0] elapsed;
		logic [31:0] raw_h;
		logic [31:0] raw_t;
		logic [11:0] temp_out;
		r = '0;
		if (w.operation == OP_TRIGGER) begin
			if (seq_state == ST_IDLE) begin
				seq_state          = ST_TRIGGER;
				r.trigger_accepted = 1'b1;
			end
		end else begin
			case (seq_state)
				ST_BOOT: begin
					if (w.now_ms > {16'd0, boot_delay})
						seq_state = ST_STATUS;
				end
				ST_STATUS: begin
					if (!w.bus_busy) begin
						r.issue_read  = 1'b1;
						r.read_length = LEN_STATUS;
						seq_state     = ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (w.rx_ready) begin
						r.rx_taken = 1'b1;
						seq_state  = w.rx_bytes[40 + STATUS_CAL_BIT] ? ST_IDLE : ST_SEND_CAL;
					end
				end
				ST_SEND_CAL, ST_TRIGGER: begin
					if (!w.bus_busy) begin
						r.issue_write   = 1'b1;
						r.command_bytes = (seq_state == ST_SEND_CAL) ? CMD_CALIBRATE
						                                             : CMD_MEASURE;
						start_ms        = w.now_ms;
						seq_state       = ST_WAIT;
					end
				end
				ST_WAIT: begin
					// elapsed time wraps modulo 2^32
					elapsed = w.now_ms - start_ms;
					if (elapsed >= {16'd0, wait_ms}) begin
						r.issue_read  = 1'b1;
						r.read_length = LEN_MEASURE;
						seq_state     = ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (w.rx_ready) begin
						r.rx_taken = 1'b1;
						// sensor still busy: keep the last reading
						if (!w.rx_bytes[40 + STATUS_BUSY_BIT]) begin
							raw_h        = {12'd0, w.rx_bytes[39:20]};
							raw_t        = {12'd0, w.rx_bytes[19:0]};
							hum_tenths   = 10'((raw_h * 32'(HUM_SCALE)) >> 20);
							temp_scaled  = 11'((raw_t * 32'(TEMP_SCALE)) >> 20);
							have_reading = 1'b1;
							readings_stored++;
						end
						seq_state = ST_IDLE;
					end
				end
				default: ;
			endcase
		end
		temp_out             = {1'b0, temp_scaled} - TEMP_OFFSET;
		r.humidity_tenths    = hum_tenths;
		r.temperature_tenths = temp_out;
		r.reading_valid      = have_reading;
		pending_results.push_back(r);
	endfunction

	function void cmp_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// one accepted result word against the oldest prediction
	function void check_word(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result word with no prediction pending");
			fails++;
			return;
		end
		want = pending_results.pop_front();
		checked++;
		cmp_field("trigger_accepted", want.trigger_accepted, got.trigger_accepted);
		cmp_field("issue_write", want.issue_write, got.issue_write);
		cmp_field("command_bytes", want.command_bytes, got.command_bytes);
		cmp_field("issue_read", want.issue_read, got.issue_read);
		cmp_field("read_length", want.read_length, got.read_length);
		cmp_field("rx_taken", want.rx_taken, got.rx_taken);
		cmp_field("humidity_tenths", want.humidity_tenths, got.humidity_tenths);
		cmp_field("temperature_tenths", $signed(want.temperature_tenths),
		          $signed(got.temperature_tenths));
		cmp_field("reading_valid", want.reading_valid, got.reading_valid);
	endfunction

	function int pending();
		return pending_results.size();
	endfunction
endclass

module tb;

	localparam int GAP_MAX         = 18;
	localparam int DRAIN_CYCLES    = 6;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int PHASES          = 12;
	localparam int WORDS_PER_PHASE = 120;
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] now_ms;
	logic        bus_busy;
	logic        rx_ready;
	logic [47:0] rx_bytes;
	logic        out_valid;
	logic        out_stall;
	logic        trigger_accepted;
	logic        issue_write;
	logic [23:0] command_bytes;
	logic        issue_read;
	logic [2:0]  read_length;
	logic        rx_taken;
	logic [9:0]  humidity_tenths;
	logic signed [11:0] temperature_tenths;
	logic        reading_valid;

	reading_scoreboard sb;
	logic [31:0] clock_ms;   // running time handed to the block
	logic        calm;       // no idling on either side while set
	int          idle_cycles;
	int          words_sent;

	humidity_sensor_sequencer_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.operation          (operation),
		.now_ms             (now_ms),
		.bus_busy           (bus_busy),
		.rx_ready           (rx_ready),
		.rx_bytes           (rx_bytes),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.trigger_accepted   (trigger_accepted),
		.issue_write        (issue_write),
		.command_bytes      (command_bytes),
		.issue_read         (issue_read),
		.read_length        (read_length),
		.rx_taken           (rx_taken),
		.humidity_tenths    (humidity_tenths),
		.temperature_tenths (temperature_tenths),
		.reading_valid      (reading_valid)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// result check and watchdog
	always @(posedge clk) begin
		result_t got;
		if (out_valid && !out_stall) begin
			got = '{trigger_accepted, issue_write, command_bytes, issue_read,
			        read_length, rx_taken, humidity_tenths, temperature_tenths,
			        reading_valid};
			sb.check_word(got);
		end
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: stall a random number of cycles ahead of each result word
	initial begin
		int n;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			n = calm ? 0 : $urandom_range(0, GAP_MAX);
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	// send one word; entered and left at a falling edge, valid left high
	task automatic push(item_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		operation = w.operation;
		now_ms    = w.now_ms;
		bus_busy  = w.bus_busy;
		rx_ready  = w.rx_ready;
		rx_bytes  = w.rx_bytes;
		do @(posedge clk); while (in_stall);
		sb.note_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_word(logic op, logic [31:0] t, logic busy, logic rdy,
	                         logic [47:0] bytes);
		item_t w;
		w = '{op, t, busy, rdy, bytes};
		push(w);
	endtask

	// let every word in flight come out before touching registers
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(logic [1:0] idx, logic [15:0] data);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// random word shaped by the predicted state, mostly well-formed
	function automatic item_t draw_item();
		item_t       w;
		int          r;
		logic [31:0] d;
		logic [31:0] wait32;
		w.rx_bytes = {16'($urandom), $urandom};
		r = $urandom_range(0, 9);
		if (r == 0)
			w.rx_bytes = '1;
		else if (r == 1)
			w.rx_bytes = '0;
		w.bus_busy = ($urandom_range(0, 2) == 0);
		if (sb.seq_state == ST_IDLE)
			w.operation = ($urandom_range(0, 9) < 7) ? OP_TRIGGER : OP_TICK;
		else
			w.operation = ($urandom_range(0, 9) == 0) ? OP_TRIGGER : OP_TICK;
		if (sb.seq_state == ST_EVAL || sb.seq_state == ST_FETCH)
			w.rx_ready = ($urandom_range(0, 4) < 3);
		else
			w.rx_ready = ($urandom_range(0, 4) == 0);
		if (sb.seq_state == ST_FETCH)
			w.rx_bytes[40 + STATUS_BUSY_BIT] = ($urandom_range(0, 3) == 0);
		// time: land around the end of the wait, else drift or jump
		wait32 = {16'd0, sb.wait_ms};
		if (sb.seq_state == ST_WAIT && w.operation == OP_TICK) begin
			case ($urandom_range(0, 5))
				0:       d = (wait32 == 0) ? 32'd0 : wait32 - 32'd1;
				1, 2:    d = wait32;
				3:       d = wait32 + $urandom_range(1, 1000);
				4:       d = $urandom;
				default: d = $urandom_range(0, sb.wait_ms);
			endcase
			clock_ms = sb.start_ms + d;
		end else if ($urandom_range(0, 49) == 0) begin
			clock_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFF0 + $urandom_range(0, 15);
		end else begin
			clock_ms = clock_ms + $urandom_range(0, 3);
		end
		w.now_ms = clock_ms;
		return w;
	endfunction

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		operation   = OP_TICK;
		now_ms      = '0;
		bus_busy    = 1'b0;
		rx_ready    = 1'b0;
		rx_bytes    = '0;
		calm        = 1'b0;
		clock_ms    = '0;
		idle_cycles = 0;
		words_sent  = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// boot wait: time must be strictly above the delay
		send_word(OP_TICK, 32'd0, 1'b0, 1'b0, 48'h0);
		send_word(OP_TRIGGER, 32'd0, 1'b0, 1'b0, 48'h0);
		send_word(OP_TICK, 32'd40, 1'b0, 1'b0, 48'h0);
		settle();
		put_reg(CFG_POWER_ON_DELAY, 16'hFFFF);
		send_word(OP_TICK, 32'd65535, 1'b0, 1'b0, 48'h0);
		settle();
		put_reg(CFG_POWER_ON_DELAY, 16'h0000);
		put_reg(CFG_DEVICE_ADDRESS, 16'h0000);
		put_reg(CFG_UNUSED_INDEX, 16'hFFFF);
		send_word(OP_TICK, 32'd0, 1'b0, 1'b0, 48'h0);
		send_word(OP_TICK, 32'd1, 1'b0, 1'b0, 48'h0);
		// status read held off by a busy bus, stray rx_ready ignored
		send_word(OP_TICK, 32'd2, 1'b1, 1'b0, 48'h0);
		send_word(OP_TICK, 32'd3, 1'b0, 1'b1, '1);
		send_word(OP_TICK, 32'd4, 1'b1, 1'b0, 48'h0);
		// calibrated bit clear: calibration command follows
		send_word(OP_TICK, 32'd5, 1'b0, 1'b1, 48'hF7FF_FFFF_FFFF);
		send_word(OP_TICK, 32'd6, 1'b1, 1'b0, 48'h0);
		// wait that wraps through zero, short by one then exact
		send_word(OP_TICK, 32'hFFFF_FFD0, 1'b0, 1'b1, 48'h0);
		send_word(OP_TICK, 32'h0000_001F, 1'b0, 1'b0, 48'h0);
		send_word(OP_TRIGGER, 32'h0000_001F, 1'b0, 1'b0, 48'h0);
		send_word(OP_TICK, 32'h0000_0020, 1'b1, 1'b0, 48'h0);
		send_word(OP_TICK, 32'h0000_0021, 1'b1, 1'b0, 48'h0);
		// full-scale reading
		send_word(OP_TICK, 32'h0000_0022, 1'b0, 1'b1, 48'h7FFF_FFFF_FFFF);
		send_word(OP_TICK, 32'h0000_0023, 1'b0, 1'b1, 48'h0);
		send_word(OP_TRIGGER, 32'h0000_0023, 1'b0, 1'b0, 48'h0);
		send_word(OP_TRIGGER, 32'h0000_0023, 1'b0, 1'b0, 48'h0);
		send_word(OP_TICK, 32'h0000_0024, 1'b1, 1'b0, 48'h0);
		send_word(OP_TICK, 32'h0000_0025, 1'b0, 1'b0, 48'h0);
		settle();
		put_reg(CFG_MEASURE_WAIT, 16'h0000);
		// zero wait; sensor busy keeps the stored reading
		send_word(OP_TICK, 32'h0000_0025, 1'b0, 1'b0, 48'h0);
		send_word(OP_TICK, 32'h0000_0026, 1'b0, 1'b1, 48'h80FF_FFFF_FFFF);
		// zero-scale reading
		send_word(OP_TRIGGER, 32'h0000_0026, 1'b0, 1'b0, 48'h0);
		send_word(OP_TICK, 32'h0000_0027, 1'b0, 1'b0, 48'h0);
		send_word(OP_TICK, 32'h0000_0027, 1'b0, 1'b0, 48'h0);
		send_word(OP_TICK, 32'h0000_0028, 1'b0, 1'b1, 48'h0);
		clock_ms = 32'h0000_0028;

		// random phases under several register settings
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 6)
				0:       put_reg(CFG_MEASURE_WAIT, 16'hFFFF);
				1:       put_reg(CFG_MEASURE_WAIT, 16'h0000);
				2:       put_reg(CFG_MEASURE_WAIT, 16'h0001);
				3:       put_reg(CFG_MEASURE_WAIT, MEASURE_WAIT_RST);
				4:       put_reg(CFG_MEASURE_WAIT, 16'hFFFE);
				default: put_reg(CFG_MEASURE_WAIT, 16'($urandom_range(2, 5000)));
			endcase
			case (p % 3)
				0:       put_reg(CFG_POWER_ON_DELAY, 16'h0000);
				1:       put_reg(CFG_POWER_ON_DELAY, 16'hFFFF);
				default: put_reg(CFG_POWER_ON_DELAY, 16'($urandom));
			endcase
			case (p % 3)
				0:       put_reg(CFG_DEVICE_ADDRESS, 16'h007F);
				1:       put_reg(CFG_DEVICE_ADDRESS, 16'($urandom));
				default: put_reg(CFG_DEVICE_ADDRESS, 16'h0000);
			endcase
			if (p % 2 == 0)
				put_reg(CFG_UNUSED_INDEX, 16'($urandom));
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if (i % 30 == 0)
					calm = ($urandom_range(0, 3) == 0);
				push(draw_item());
			end
		end

		// drain and finish
		in_valid = 1'b0;
		calm     = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d input words over %0d register phases; %0d results checked.",
		         words_sent, PHASES, sb.checked);
		$display("Measurements converted and stored: %0d.", sb.readings_stored);
		if (sb.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
